>>> hw/rtl/srms_agc_pkg.sv
// Package for the sliding-window rms gain control: word types, register indexes, constants.
package srms_agc_pkg;

   localparam int SAMPLE_W            = 24;
   localparam int OUT_W               = 24;
   localparam int HW_W                = 6;
   localparam int CSR_ADDR_W          = 2;
   localparam int CSR_DATA_W          = 8;
   localparam int MAX_HALF_WINDOW_DEF = 63;
   localparam int HALF_WINDOW_RESET   = 31;

   // Fraction bits of the mean square in gain mode, and of the gain numerator.
   localparam int MSQ_FRAC   = 16;
   localparam int GAIN_SHIFT = 24;

   // Root unit works on a 64-bit radicand, two bits per step.
   localparam int ROOT_W     = 64;
   localparam int ROOT_STEPS = ROOT_W / 2;
   localparam int DEN_W      = ROOT_W / 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_WINDOW = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_OUTPUT_MODE = CSR_ADDR_W'(1);

   localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       end_of_trace;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] value;
      logic                    last_of_trace;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_PLAN,
      ST_FLUSH,
      ST_EMIT,
      ST_EVICT_SQ,
      ST_EVICT_SUB,
      ST_SAMPLE_GET,
      ST_DIVIDE,
      ST_DIV_END,
      ST_ROOT,
      ST_ROOT_END,
      ST_RESULT
   } agc_state_type;

endpackage

>>> hw/rtl/sliding_rms_agc_unit.sv
// Sliding-window rms automatic gain control: ring memory, running sum, serial divide and root.
//
// Usage:
//  Request words carry one trace sample and an end-of-trace flag; samples of a
//  trace arrive in order. A word is taken when req_valid is high and req_stall
//  low. Result words leave on rsp_valid/rsp_stall through an output register,
//  so a stalled result holds the block only once the next result is ready.
//  Result o covers samples o-W..o+W clipped at the trace ends. Results lag the
//  input by W samples; the end-of-trace word flushes the results still owed.
//  Mode 0 gives the sample over the rms in Q16, mode 1 the integer rms; both
//  saturate to 24 bits signed, and a zero window energy gives zero.
//  The CSR port (csr_valid/csr_ready, always ready) writes half_window (index
//  0) and output_mode (index 1); write them only while the block is idle.
//  half_window is latched at the first sample of each trace.
// Timing:
//  Taking a sample stalls the request side through the square, accumulate, plan
//  and flush steps, plus one result when one is due. A result runs a divide, a
//  root and a second divide in gain mode and a divide and a root in scale mode,
//  with a square and a subtract step first when a sample leaves the window; a
//  zero window energy skips both. The single serial divider (one quotient bit
//  a cycle) and the root unit (two radicand bits a cycle) set the length of a
//  result. A full, stalled output register holds the block in its result
//  state. The end of a trace adds up to W more results.
// Reset:
//  Synchronous, active high: clears the trace state and the output valid flag,
//  loads half_window = 31, output_mode = 0. The sample ring holds no reset.
module sliding_rms_agc_unit #(
   parameter int MAX_HALF_WINDOW = srms_agc_pkg::MAX_HALF_WINDOW_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  srms_agc_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output srms_agc_pkg::rsp_type               rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [srms_agc_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [srms_agc_pkg::CSR_DATA_W-1:0] csr_data
);
   import srms_agc_pkg::*;

   localparam int RING_DEPTH = 2 * MAX_HALF_WINDOW + 2;
   localparam int AW         = $clog2(RING_DEPTH);
   localparam int CW         = $clog2(RING_DEPTH + 1);
   localparam int WW         = $clog2(MAX_HALF_WINDOW + 1);
   localparam int BW         = AW + 2;
   localparam int SQ_W       = 2 * SAMPLE_W;
   localparam int SUM_W      = SQ_W + AW;
   localparam int NUM_W      = SUM_W + MSQ_FRAC;
   localparam int GNUM_W     = SAMPLE_W + GAIN_SHIFT;
   localparam int STEP_W     = $clog2(NUM_W + 1);

   // Sample ring: one write port, one registered read port.
   logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
   logic [SAMPLE_W-1:0] rd_ff;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;

   // Configuration.
   logic [HW_W-1:0] hw_ff, hw_in;
   logic            mode_ff, mode_in;

   // Trace control.
   agc_state_type   state_ff, state_in;
   logic [CW-1:0]   seen_ff, seen_in;
   logic [AW-1:0]   head_ff, head_in;
   logic [WW-1:0]   tw_ff, tw_in;
   logic [WW-1:0]   d_ff, d_in;
   logic            eot_ff, eot_in;
   logic            flush_ff, flush_in;
   logic            last_ff, last_in;
   logic            second_ff, second_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic            out_valid_ff, out_valid_in;

   // Datapath.
   logic [SAMPLE_W-1:0] smp_ff, smp_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [ROOT_W-1:0]   rad_ff, rad_in;
   logic [ROOT_W-1:0]   res_ff, res_in;
   logic [ROOT_W-1:0]   bit_ff, bit_in;
   logic [OUT_W-1:0]    val_ff, val_in;
   rsp_type             out_ff, out_in;

   // Combinational helpers.
   logic [WW-1:0]       tw_clamp;
   logic [WW-1:0]       w_new;
   logic [CW-1:0]       seen_max;
   logic [CW-1:0]       lim;
   logic [CW-1:0]       cnt;
   logic [CW-1:0]       first;
   logic [CW-1:0]       back_k;
   logic [BW-1:0]       idx_w;
   logic [SAMPLE_W-1:0] mag_src;
   logic [SAMPLE_W-1:0] mag_val;
   logic [SQ_W-1:0]     sq_prod;
   logic [DEN_W:0]      rem_sh;
   logic                div_ge;
   logic [ROOT_W-1:0]   root_try;
   logic [GNUM_W-1:0]   quo;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      tw_clamp = (int'(hw_ff) > MAX_HALF_WINDOW) ? WW'(MAX_HALF_WINDOW) : WW'(hw_ff);
      w_new    = (seen_ff == '0) ? tw_clamp : tw_ff;
      seen_max = CW'({w_new, 1'b0}) + CW'(2);
      lim      = CW'(d_ff) + CW'(tw_ff) + CW'(1);
      cnt      = (seen_ff < lim) ? seen_ff : lim;
      if (cnt == '0) begin
         cnt = CW'(1);
      end
      first    = (seen_ff < CW'(tw_ff)) ? seen_ff : CW'(tw_ff);

      // Ring index of the sample back_k places behind the newest one.
      back_k = (state_ff == ST_EMIT && seen_ff > lim) ? lim : CW'(d_ff);
      idx_w  = BW'(head_ff) + BW'(RING_DEPTH - 1) - BW'(back_k);
      if (idx_w >= BW'(RING_DEPTH)) begin
         idx_w = idx_w - BW'(RING_DEPTH);
      end
      rd_addr = idx_w[AW-1:0];

      // One squarer, shared by the incoming sample and the evicted one.
      mag_src = (state_ff == ST_SQUARE) ? smp_ff : rd_ff;
      mag_val = mag_src[SAMPLE_W-1] ? (~mag_src + SAMPLE_W'(1)) : mag_src;
      sq_prod = SQ_W'(mag_val) * SQ_W'(mag_val);

      // Restoring divider step and root step.
      rem_sh   = {rem_ff, num_ff[NUM_W-1]};
      div_ge   = (rem_sh >= {1'b0, den_ff});
      root_try = res_ff + bit_ff;
      quo      = num_ff[GNUM_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      hw_in        = hw_ff;
      mode_in      = mode_ff;
      seen_in      = seen_ff;
      head_in      = head_ff;
      tw_in        = tw_ff;
      d_in         = d_ff;
      eot_in       = eot_ff;
      flush_in     = flush_ff;
      last_in      = last_ff;
      second_in    = second_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      smp_in       = smp_ff;
      sq_in        = sq_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      rad_in       = rad_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      val_in       = val_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff & rsp_stall;
      rd_en        = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            CSR_HALF_WINDOW: hw_in   = csr_data[HW_W-1:0];
            CSR_OUTPUT_MODE: mode_in = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               smp_in = req_data.sample;
               eot_in = req_data.end_of_trace;
               if (seen_ff == '0) begin
                  tw_in  = tw_clamp;
                  sum_in = '0;
               end
               if (seen_ff < seen_max) begin
                  seen_in = seen_ff + CW'(1);
               end
               head_in  = (head_ff == AW'(RING_DEPTH - 1)) ? '0 : head_ff + AW'(1);
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            sq_in    = sq_prod;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            sum_in   = sum_ff + SUM_W'(sq_ff);
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            if (seen_ff >= CW'(tw_ff) + CW'(1)) begin
               d_in     = tw_ff;
               last_in  = eot_ff && (tw_ff == '0);
               flush_in = 1'b0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!eot_ff) begin
               state_in = ST_IDLE;
            end else if (first == '0) begin
               seen_in  = '0;
               sum_in   = '0;
               state_in = ST_IDLE;
            end else begin
               d_in     = WW'(first - CW'(1));
               last_in  = (first == CW'(1));
               flush_in = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rd_en    = 1'b1;
            state_in = (seen_ff > lim) ? ST_EVICT_SQ : ST_SAMPLE_GET;
         end
         ST_EVICT_SQ: begin
            sq_in    = sq_prod;
            state_in = ST_EVICT_SUB;
         end
         ST_EVICT_SUB: begin
            sum_in   = sum_ff - SUM_W'(sq_ff);
            rd_en    = 1'b1;
            state_in = ST_SAMPLE_GET;
         end
         ST_SAMPLE_GET: begin
            if (sum_ff == '0) begin
               val_in   = '0;
               state_in = ST_RESULT;
            end else begin
               num_in    = {sum_ff, {MSQ_FRAC{1'b0}}};
               rem_in    = '0;
               den_in    = DEN_W'(cnt);
               step_in   = STEP_W'(NUM_W);
               second_in = 1'b0;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in  = div_ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
            num_in  = {num_ff[NUM_W-2:0], div_ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_END: begin
            if (!second_ff) begin
               // Mean square: Q16 in gain mode (saturated to 64 bits), integer in scale mode.
               if (mode_ff) begin
                  rad_in = ROOT_W'(num_ff[NUM_W-1:MSQ_FRAC]);
               end else if (|num_ff[NUM_W-1:ROOT_W]) begin
                  rad_in = '1;
               end else begin
                  rad_in = num_ff[ROOT_W-1:0];
               end
               res_in   = '0;
               bit_in   = ROOT_W'(1) << (ROOT_W - 2);
               step_in  = STEP_W'(ROOT_STEPS);
               state_in = ST_ROOT;
            end else begin
               if (rd_ff[SAMPLE_W-1]) begin
                  val_in = (quo > GNUM_W'(OUT_MIN)) ? OUT_MIN : OUT_W'(0) - quo[OUT_W-1:0];
               end else begin
                  val_in = (quo > GNUM_W'(OUT_MAX)) ? OUT_MAX : quo[OUT_W-1:0];
               end
               state_in = ST_RESULT;
            end
         end
         ST_ROOT: begin
            if (rad_ff >= root_try) begin
               rad_in = rad_ff - root_try;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_ROOT_END;
            end
         end
         ST_ROOT_END: begin
            if (mode_ff) begin
               val_in   = (res_ff > ROOT_W'(OUT_MAX)) ? OUT_MAX : res_ff[OUT_W-1:0];
               state_in = ST_RESULT;
            end else begin
               // Gain: |x| * 2^24 over the Q8 rms, numerator left aligned.
               num_in    = {mag_val, {(NUM_W-SAMPLE_W){1'b0}}};
               rem_in    = '0;
               den_in    = (res_ff == '0) ? DEN_W'(1) : res_ff[DEN_W-1:0];
               step_in   = STEP_W'(GNUM_W);
               second_in = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_RESULT: begin
            // Hold here only while the output register is full and stalled.
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in         = 1'b1;
               out_in.value         = val_ff;
               out_in.last_of_trace = last_ff;
               if (!flush_ff) begin
                  state_in = ST_FLUSH;
               end else if (d_ff == '0) begin
                  seen_in  = '0;
                  sum_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  d_in     = d_ff - WW'(1);
                  last_in  = (d_ff == WW'(1));
                  state_in = ST_EMIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff        <= HW_W'(HALF_WINDOW_RESET);
         mode_ff      <= 1'b0;
         state_ff     <= ST_IDLE;
         seen_ff      <= '0;
         head_ff      <= '0;
         tw_ff        <= '0;
         d_ff         <= '0;
         eot_ff       <= 1'b0;
         flush_ff     <= 1'b0;
         last_ff      <= 1'b0;
         second_ff    <= 1'b0;
         step_ff      <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         hw_ff        <= hw_in;
         mode_ff      <= mode_in;
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         head_ff      <= head_in;
         tw_ff        <= tw_in;
         d_ff         <= d_in;
         eot_ff       <= eot_in;
         flush_ff     <= flush_in;
         last_ff      <= last_in;
         second_ff    <= second_in;
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff <= smp_in;
      sq_ff  <= sq_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      rad_ff <= rad_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      val_ff <= val_in;
      out_ff <= out_in;
   end

   // Write the new sample at the head; read one entry a cycle while rd_en is set.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         ring_mem[head_ff] <= req_data.sample;
      end
      if (rd_en) begin
         rd_ff <= ring_mem[rd_addr];
      end
   end

   seen_bound_a: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CW'({tw_ff, 1'b0}) + CW'(2))
      else $error("sample count exceeds the window span");

   trace_clear_a: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && eot_ff && first == '0) |=> (seen_ff == '0 && sum_ff == '0))
      else $error("trace state not cleared at end of trace");

   div_rem_a: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   rd_addr_a: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (int'(rd_addr) < RING_DEPTH))
      else $error("ring read address out of range");

endmodule

>>> tb/sliding_rms_agc_unit_tb.sv
// Testbench for the sliding-window rms gain control: directed table, random traces, checking.
`timescale 1ns / 100ps

module sliding_rms_agc_unit_tb;
   import srms_agc_pkg::*;

   localparam int RING_N = 128;
   localparam int DRAIN_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   sliding_rms_agc_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expected result words, oldest first.
   rsp_type agc_expected[$];
   int errors = 0;
   int words_sent = 0;

   // Shadow of the block: ring, running energy, trace position, registers.
   logic signed [SAMPLE_W-1:0] shadow_ring[RING_N];
   longint unsigned energy;
   int unsigned seen, head, win_count, trace_hw;
   int unsigned reg_hw = HALF_WINDOW_RESET;
   bit reg_mode = 1'b0;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned abs_of(longint signed x);
      return x < 0 ? longint'(0) - x : x;
   endfunction

   function automatic longint signed ring_back(int unsigned k);
      return shadow_ring[(head + RING_N - 1 - (k % RING_N)) % RING_N];
   endfunction

   // Compute the result for the sample d places behind the newest one.
   task automatic push_window_result(int unsigned d, bit last);
      int unsigned lim;
      longint unsigned cnt, q, r, msq, rq, quo, m;
      longint signed x;
      logic [OUT_W-1:0] v;
      rsp_type w;
      lim = d + trace_hw + 1;
      if (seen > lim) begin
         m = abs_of(ring_back(lim));
         energy -= m * m;
      end
      cnt = seen < lim ? seen : lim;
      if (cnt == 0) cnt = 1;
      win_count = 32'(cnt);
      x = ring_back(d);
      if (energy == 0) begin
         v = '0;
      end else if (reg_mode) begin
         q = int_sqrt(energy / cnt);
         v = q > OUT_MAX ? OUT_MAX : q[OUT_W-1:0];
      end else begin
         q = energy / cnt;
         r = energy % cnt;
         if (q >= (64'd1 << 48)) msq = '1;
         else msq = (q << MSQ_FRAC) + (r << MSQ_FRAC) / cnt;
         rq = int_sqrt(msq);
         if (rq == 0) rq = 1;
         quo = (abs_of(x) << GAIN_SHIFT) / rq;
         if (x < 0) begin
            if (quo > 64'd8388608) quo = 64'd8388608;
            v = OUT_W'(longint'(0) - quo);
         end else begin
            v = quo > OUT_MAX ? OUT_MAX : quo[OUT_W-1:0];
         end
      end
      w.value = v;
      w.last_of_trace = last;
      agc_expected.push_back(w);
   endtask

   task automatic predict_word(req_type r);
      longint signed x;
      longint unsigned m;
      int unsigned first;
      x = r.sample;
      m = abs_of(x);
      if (seen == 0) begin
         energy = 0;
         trace_hw = reg_hw;
      end
      shadow_ring[head] = r.sample;
      head = (head + 1) % RING_N;
      energy += m * m;
      if (seen < 2 * trace_hw + 2) seen++;
      if (seen >= trace_hw + 1) push_window_result(trace_hw, r.end_of_trace && trace_hw == 0);
      if (r.end_of_trace) begin
         first = seen < trace_hw ? seen : trace_hw;
         for (int unsigned d = first; d > 0; d--) push_window_result(d - 1, d == 1);
         seen = 0;
         energy = 0;
      end
   endtask

   // Sender: hold the word until accepted, then predict.
   task automatic send_word(logic [SAMPLE_W-1:0] s, bit eot, int gap);
      req_type r;
      r.sample = s;
      r.end_of_trace = eot;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      predict_word(r);
      words_sent++;
   endtask

   // Hold one write until taken; the caller drops valid after its last write.
   task automatic csr_write(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Drain all results, let the block settle, then load both registers.
   task automatic load_setup(int unsigned hw, bit mode);
      logic [1:0] junk;
      req_valid <= 1'b0;
      @(posedge clock);
      while (agc_expected.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      junk = 2'($urandom);
      csr_write(CSR_HALF_WINDOW, {junk, 6'(hw)});
      csr_write(CSR_OUTPUT_MODE, {7'($urandom), mode});
      csr_valid <= 1'b0;
      reg_hw = hw;
      reg_mode = mode;
   endtask

   // Receiver: random stall per word, with stretches of no stall.
   initial begin
      int gap;
      int calm;
      rsp_type got, want;
      calm = 0;
      @(negedge reset);
      forever begin
         if (calm > 0) begin
            calm--;
            gap = 0;
         end else begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 19) == 0) calm = $urandom_range(5, 40);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got = rsp_data;
         if (agc_expected.size() == 0) begin
            $error("unexpected result word: value %0d last %0d",
                   $signed(got.value), got.last_of_trace);
            errors++;
         end else begin
            want = agc_expected.pop_front();
            if (got.value !== want.value) begin
               $error("value: expected %0d, actual %0d", $signed(want.value),
                      $signed(got.value));
               errors++;
            end
            if (got.last_of_trace !== want.last_of_trace) begin
               $error("last_of_trace: expected %0d, actual %0d", want.last_of_trace,
                      got.last_of_trace);
               errors++;
            end
         end
      end
   end

   // Directed table: a row with new_setup loads registers before its trace starts.
   typedef struct {
      bit new_setup;
      int unsigned hw;
      bit mode;
      logic [SAMPLE_W-1:0] s;
      bit eot;
      bit typed;
      logic [OUT_W-1:0] v;
   } agc_row;

   agc_row rows[] = '{
      // reset setup: W=31, gain mode, one-sample trace gives unity gain
      '{0, 0, 0, 24'd1000, 1, 1, 24'd65536},
      // W=0 gain mode: extremes and zero energy
      '{1, 0, 0, 24'h7FFFFF, 1, 1, 24'd65536},
      '{0, 0, 0, 24'h800000, 1, 1, 24'hFF0000},
      '{0, 0, 0, 24'd0, 1, 1, 24'd0},
      // W=0 scale mode: most negative saturates
      '{1, 0, 1, 24'h800000, 1, 1, 24'h7FFFFF},
      '{0, 0, 1, 24'h7FFFFF, 1, 1, 24'h7FFFFF},
      '{0, 0, 1, 24'd1, 1, 1, 24'd1},
      // W=2 scale mode, leading zeros, eviction before the end
      '{1, 2, 1, 24'd0, 0, 0, 0},
      '{0, 2, 1, 24'd0, 0, 0, 0},
      '{0, 2, 1, 24'd0, 0, 0, 0},
      '{0, 2, 1, 24'd5, 0, 0, 0},
      '{0, 2, 1, 24'hFFFFFD, 0, 0, 0},
      '{0, 2, 1, 24'h7FFFFF, 1, 0, 0},
      // widest window, trace shorter than W
      '{1, 63, 0, 24'd7, 0, 0, 0},
      '{0, 63, 0, 24'h800000, 0, 0, 0},
      '{0, 63, 0, 24'd12, 0, 0, 0},
      '{0, 63, 0, 24'd0, 1, 0, 0},
      // all-zero trace, then a W=3 scale mode trace
      '{1, 1, 0, 24'd0, 0, 0, 0},
      '{0, 1, 0, 24'd0, 0, 0, 0},
      '{0, 1, 0, 24'd0, 1, 0, 0},
      '{1, 3, 1, 24'hFFFFFF, 0, 0, 0},
      '{0, 3, 1, 24'd100, 0, 0, 0},
      '{0, 3, 1, 24'd2, 1, 0, 0}
   };

   function automatic logic [SAMPLE_W-1:0] draw_sample();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         2, 3, 4: return SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin
      int unsigned hw, len, pick;
      bit mode, burst, zero_trace;
      rsp_type typed_word;
      energy = 0;
      seen = 0;
      head = 0;
      win_count = 0;
      trace_hw = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].new_setup) load_setup(rows[i].hw, rows[i].mode);
         send_word(rows[i].s, rows[i].eot, $urandom_range(0, 9));
         // Replace the predicted word by the one read off the definition.
         if (rows[i].typed) begin
            typed_word.value = rows[i].v;
            typed_word.last_of_trace = 1'b1;
            void'(agc_expected.pop_back());
            agc_expected.push_back(typed_word);
         end
      end

      // Random traces: mostly small windows, some wide, some long enough to evict.
      while (words_sent < 370) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) hw = 63;
         else if (pick == 1) hw = $urandom_range(11, 62);
         else hw = $urandom_range(0, 10);
         mode = $urandom_range(0, 1);
         load_setup(hw, mode);
         pick = $urandom_range(0, 2);
         if (pick == 0) len = $urandom_range(1, hw + 1);
         else if (pick == 1) len = 2 * hw + 2 + $urandom_range(0, 20);
         else len = $urandom_range(1, 2 * hw + 2);
         if (hw > 10 && pick != 1) len = $urandom_range(1, 12);
         burst = $urandom_range(0, 3) == 0;
         zero_trace = $urandom_range(0, 15) == 0;
         for (int unsigned k = 0; k < len; k++)
            send_word(zero_trace ? '0 : draw_sample(), k == len - 1,
                      burst ? 0 : $urandom_range(0, 9));
      end
      req_valid <= 1'b0;

      while (agc_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && agc_expected.size() == 0) begin
         $display("sliding_rms_agc_unit_tb: clean");
      end else begin
         $display("sliding_rms_agc_unit_tb: errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #200ms;
      $display("sliding_rms_agc_unit_tb: errors");
      $finish;
   end

endmodule
